### hdl/lrb_pkg.sv
// ----------------------------------------------------------------------------
// lrb_pkg: shared types and constants for the light range search
// Fixed-point formats, field widths, status codes and request/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lrb_pkg;

  // Level is Q1.LEVEL_FRAC_BITS, distance is Q14.DISTANCE_FRAC_BITS.
  localparam int LEVEL_FRAC_BITS    = 16;
  localparam int DISTANCE_FRAC_BITS = 10;
  localparam int COEFF_FRAC_BITS    = 16;
  localparam int COEFF_W            = 24;

  localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
  localparam int DIST_W  = 14 + DISTANCE_FRAC_BITS;
  localparam int MUL_W   = (DIST_W > COEFF_W) ? DIST_W : COEFF_W;
  localparam int PROD_W  = 2 * MUL_W;
  // q * d * d before scaling, and the denominator after scaling
  localparam int QDD_W   = COEFF_W + 2 * DIST_W;
  localparam int DEN_W   = QDD_W - 2 * DISTANCE_FRAC_BITS + 2;
  // dividend 2^(16+L) and its register width
  localparam int NUM_W   = COEFF_FRAC_BITS + LEVEL_FRAC_BITS + 1;
  localparam int QUO_W   = LEVEL_FRAC_BITS;
  localparam int THR_W   = LEVEL_W + COEFF_FRAC_BITS;
  localparam int BAND_W  = LEVEL_W + 2;
  localparam int ITER_W  = 7;

  localparam logic [DIST_W-1:0] FAR_DIST = DIST_W'(10000 << DISTANCE_FRAC_BITS);
  localparam logic [ITER_W-1:0] LIMIT_CAP   = ITER_W'(64);
  localparam logic [ITER_W-1:0] LIMIT_RESET = ITER_W'(32);
  localparam logic [DEN_W-1:0]  LOOP_THRESH = DEN_W'(6);
  localparam logic [DEN_W-1:0]  DEN_UNITY   = DEN_W'(1) << COEFF_FRAC_BITS;

  // floor(t / 10) = (t * RECIP_TEN) >> RECIP_SHIFT for any level-wide t
  localparam int                RECIP_SHIFT = 23;
  localparam logic [MUL_W-1:0]  RECIP_TEN   = MUL_W'(838861);

  localparam logic [1:0] STAT_IN_BAND   = 2'd0;
  localparam logic [1:0] STAT_TOO_FAR   = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0] target_level;
    logic [LEVEL_W-1:0] accuracy;
    logic [COEFF_W-1:0] const_coeff;
    logic [COEFF_W-1:0] linear_coeff;
    logic [COEFF_W-1:0] quad_coeff;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] range_distance;
    logic [1:0]        search_status;
  } res_t;

endpackage

`default_nettype wire

### hdl/lrb_mul.sv
// ----------------------------------------------------------------------------
// lrb_mul: shared registered multiplier
// One unsigned product per cycle, registered: the result follows in the cycle after the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module lrb_mul (
  input  wire logic                       clk,
  input  wire logic [lrb_pkg::MUL_W-1:0]  a,
  input  wire logic [lrb_pkg::MUL_W-1:0]  b,
  output logic      [lrb_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= lrb_pkg::PROD_W'(a) * lrb_pkg::PROD_W'(b);
  end

endmodule

`default_nettype wire

### hdl/lrb_div.sv
// ----------------------------------------------------------------------------
// lrb_div: shared restoring divider
// One quotient bit per cycle; quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lrb_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lrb_pkg::NUM_W-1:0] num,
  input  wire logic [lrb_pkg::DEN_W-1:0] den,
  output logic                           done,
  output logic      [lrb_pkg::QUO_W-1:0] quo
);

  localparam int SH_W = lrb_pkg::DEN_W + lrb_pkg::QUO_W;
  localparam int K_W  = (lrb_pkg::QUO_W > 1) ? $clog2(lrb_pkg::QUO_W) : 1;

  logic                      run;
  logic [K_W-1:0]            k;
  logic [lrb_pkg::NUM_W-1:0] rem;
  logic [lrb_pkg::DEN_W-1:0] dv;
  logic [SH_W-1:0]           shifted;
  logic                      fits;

  assign shifted = SH_W'(dv) << k;
  assign fits    = SH_W'(rem) >= shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        rem <= num;
        dv  <= den;
        k   <= K_W'(lrb_pkg::QUO_W - 1);
        quo <= '0;
      end else if (run) begin
        if (fits) begin
          rem    <= lrb_pkg::NUM_W'(SH_W'(rem) - shifted);
          quo[k] <= 1'b1;
        end
        if (k == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - K_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/light_range_bisection.sv
// ----------------------------------------------------------------------------
// light_range_bisection: distance at which an attenuated light meets a level
// Bisects 0..10000 for min(1, 1/(c + l*d + q*d*d)) within target +/- accuracy.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Handshake                  Payload
// request    in         start high, busy low       request (lrb_pkg::req_t)
// result     out        result_valid, one cycle    result  (lrb_pkg::res_t)
// config     in         cfg_valid && cfg_ready     cfg_data (iteration limit)
//
// Sequence: one evaluation of the diffuse level runs S_MDD, S_MQLO, S_MQHI
// and S_MLD on the shared multiplier, then S_SUM, then S_DIV on the shared
// divider when the denominator is above one and above thresh, then S_DECIDE.
// The accuracy cut, if any, is a reciprocal multiply used in S_CUT. A request
// runs at most min(iteration_limit, 64) bisection steps before its result.
// Reset clears the sequencer and sets the iteration limit to 32.
// The receiver cannot stall: each result shows for exactly one cycle.
// cfg_ready is always high.
`default_nettype none

module light_range_bisection (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire lrb_pkg::req_t               request,
  output logic                             result_valid,
  output lrb_pkg::res_t                    result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lrb_pkg::ITER_W-1:0]  cfg_data
);

  localparam int DW = lrb_pkg::DIST_W;
  localparam int MW = lrb_pkg::MUL_W;
  localparam int PW = lrb_pkg::PROD_W;
  localparam int LW = lrb_pkg::LEVEL_W;
  localparam int BW = lrb_pkg::BAND_W;
  localparam int IW = lrb_pkg::ITER_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CUT, S_MDD, S_MQLO, S_MQHI, S_MLD, S_SUM, S_DIV, S_DECIDE, S_STEP
  } state_t;

  state_t state;

  // Request, held for the whole search; the accuracy may be cut once in S_CUT.
  logic [LW-1:0]                 target;
  logic [LW-1:0]                 acc;
  logic [lrb_pkg::COEFF_W-1:0]   cc, lc, qc;

  logic [IW-1:0]                 iter_limit;
  logic [IW-1:0]                 limit_eff;
  logic [IW-1:0]                 iter;
  logic                          far_mode;
  logic [lrb_pkg::DEN_W-1:0]     thresh;
  logic [DW-1:0]                 lo, hi, dcur, mid_w;
  logic [DW-1:0]                 dd_hi;
  logic [PW-1:0]                 qlo;
  logic [lrb_pkg::QDD_W-1:0]     qdd;
  logic [lrb_pkg::DEN_W-1:0]     den_w;
  logic [LW-1:0]                 dif;
  logic signed [BW-1:0]          band_lo, band_hi, dif_s;
  logic                          cut_req;
  logic [LW-1:0]                 cut_q;

  logic [MW-1:0]                 mul_a, mul_b;
  logic [PW-1:0]                 prod;
  logic                          div_start, div_done;
  logic [lrb_pkg::NUM_W-1:0]     div_num;
  logic [lrb_pkg::DEN_W-1:0]     div_den;
  logic [lrb_pkg::QUO_W-1:0]     quo;

  lrb_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  lrb_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(quo)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign limit_eff = (iter_limit > lrb_pkg::LIMIT_CAP) ? lrb_pkg::LIMIT_CAP : iter_limit;
  assign mid_w     = lo + ((hi - lo) >> 1);

  // Cut the accuracy to a tenth of a nonzero target that it reaches.
  assign cut_req = (request.target_level != '0)
                   && (request.accuracy >= request.target_level);
  assign cut_q   = LW'(prod >> lrb_pkg::RECIP_SHIFT);

  // Band edges on a signed scale; the low edge may go below zero.
  assign band_lo = $signed(BW'(target)) - $signed(BW'(acc));
  assign band_hi = $signed(BW'(target)) + $signed(BW'(acc));
  assign dif_s   = $signed(BW'(dif));

  // Denominator in Q.16: c + floor(l*d >> D) + floor(q*d*d >> 2D).
  assign den_w = lrb_pkg::DEN_W'(cc)
               + lrb_pkg::DEN_W'(prod >> lrb_pkg::DISTANCE_FRAC_BITS)
               + lrb_pkg::DEN_W'(qdd >> (2 * lrb_pkg::DISTANCE_FRAC_BITS));

  // Multiplier operand select; d*d is split in halves for the q product.
  // While idle, form target * (1/10) so the cut is ready the next cycle.
  always_comb begin
    mul_a = MW'(dcur);
    mul_b = MW'(dcur);
    case (state)
      S_IDLE: begin
        mul_a = MW'(request.target_level);
        mul_b = lrb_pkg::RECIP_TEN;
      end
      S_MQLO: begin
        mul_a = MW'(qc);
        mul_b = MW'(prod[DW-1:0]);
      end
      S_MQHI: begin
        mul_a = MW'(qc);
        mul_b = MW'(dd_hi);
      end
      S_MLD: begin
        mul_a = MW'(lc);
        mul_b = MW'(dcur);
      end
      default: begin
        mul_a = MW'(dcur);
        mul_b = MW'(dcur);
      end
    endcase
  end

  // Divider: 2^(16+L) / den, only when den is above both one and thresh.
  always_comb begin
    div_num   = lrb_pkg::NUM_W'(1) << (lrb_pkg::COEFF_FRAC_BITS + lrb_pkg::LEVEL_FRAC_BITS);
    div_den   = den_w;
    div_start = (state == S_SUM)
                && !((den_w <= thresh) || (den_w <= lrb_pkg::DEN_UNITY));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      iter_limit   <= lrb_pkg::LIMIT_RESET;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        iter_limit <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            target   <= request.target_level;
            acc      <= request.accuracy;
            cc       <= request.const_coeff;
            lc       <= request.linear_coeff;
            qc       <= request.quad_coeff;
            far_mode <= 1'b1;
            dcur     <= lrb_pkg::FAR_DIST;
            if (cut_req) begin
              state <= S_CUT;
            end else begin
              // far-limit threshold is the accuracy on the Q.16 scale
              thresh <= lrb_pkg::DEN_W'((lrb_pkg::THR_W'(request.accuracy)
                        << lrb_pkg::COEFF_FRAC_BITS) >> lrb_pkg::LEVEL_FRAC_BITS);
              state  <= S_MDD;
            end
          end
        end
        S_CUT: begin
          acc    <= cut_q;
          thresh <= lrb_pkg::DEN_W'((lrb_pkg::THR_W'(cut_q)
                    << lrb_pkg::COEFF_FRAC_BITS) >> lrb_pkg::LEVEL_FRAC_BITS);
          state  <= S_MDD;
        end
        S_MDD: state <= S_MQLO;
        S_MQLO: begin
          dd_hi <= prod[2*DW-1:DW];
          state <= S_MQHI;
        end
        S_MQHI: begin
          qlo   <= prod;
          state <= S_MLD;
        end
        S_MLD: begin
          qdd   <= lrb_pkg::QDD_W'(qlo) + (lrb_pkg::QDD_W'(prod) << DW);
          state <= S_SUM;
        end
        S_SUM: begin
          if (div_start) begin
            state <= S_DIV;
          end else begin
            dif   <= LW'(1) << lrb_pkg::LEVEL_FRAC_BITS;
            state <= S_DECIDE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            dif   <= LW'(quo);
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (far_mode) begin
            if (dif_s > band_hi) begin
              result_valid                <= 1'b1;
              result.range_distance       <= lrb_pkg::FAR_DIST;
              result.search_status        <= lrb_pkg::STAT_TOO_FAR;
              state                       <= S_IDLE;
            end else begin
              far_mode <= 1'b0;
              thresh   <= lrb_pkg::LOOP_THRESH;
              lo       <= '0;
              hi       <= lrb_pkg::FAR_DIST;
              iter     <= '0;
              state    <= S_STEP;
            end
          end else if (dif_s < band_lo) begin
            hi    <= dcur;
            iter  <= iter + IW'(1);
            state <= S_STEP;
          end else if (dif_s > band_hi) begin
            lo    <= dcur;
            iter  <= iter + IW'(1);
            state <= S_STEP;
          end else begin
            result_valid          <= 1'b1;
            result.range_distance <= dcur;
            result.search_status  <= lrb_pkg::STAT_IN_BAND;
            state                 <= S_IDLE;
          end
        end
        S_STEP: begin
          if (iter == limit_eff) begin
            result_valid          <= 1'b1;
            result.range_distance <= mid_w;
            result.search_status  <= lrb_pkg::STAT_EXHAUSTED;
            state                 <= S_IDLE;
          end else begin
            dcur  <= mid_w;
            state <= S_MDD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result only ends a search that was running.
  a_res_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a running search");

  // The result strobe is never high in back-to-back cycles.
  a_res_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  // An accepted request starts a search.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start a search");

  // Step count never passes the capped limit.
  a_iter_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (iter <= limit_eff))
    else $error("bisection step count beyond limit");

endmodule

`default_nettype wire
